// ===== rtl/lsp_pkg.sv =====
// ----------------------------------------------------------------------------
// lsp_pkg
// Shared constants and types of the line sensor position block.
// ----------------------------------------------------------------------------
package lsp_pkg;

   localparam int CHANNELS   = 6;
   localparam int FULL_SCALE = 1000;
   localparam int TIMEOUT_US = 2500;
   localparam int LINE_MAX   = (CHANNELS - 1) * FULL_SCALE;

   localparam int RAW_W  = 12;
   localparam int CAL_W  = 10;
   localparam int POS_W  = 13;
   localparam int CMD_W  = 2;
   localparam int CSR_W  = 10;
   localparam int IDX_W  = 1;
   // 12-bit difference times 1000 fits in 22 bits
   localparam int NUM_W  = RAW_W + CAL_W;
   // sum of cal*i*1000 over channels: 6*1000*5000 < 2^25
   localparam int WSUM_W = 25;
   // sum of cal over channels: 6*1000 < 2^13
   localparam int TSUM_W = 13;

   localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_MEASURE = 2'd2;

   localparam logic [IDX_W-1:0] REG_COUNT_LEVEL = 1'b0;
   localparam logic [IDX_W-1:0] REG_LINE_LEVEL  = 1'b1;

   typedef logic [RAW_W-1:0] raw_type;
   typedef logic [CAL_W-1:0] cal_type;

   // Control handed from the sequencer to the lanes
   typedef struct packed {
      logic start;   // load numerator/denominator and begin division
   } lane_ctl_type;

endpackage

// ===== rtl/lsp_div.sv =====
// ----------------------------------------------------------------------------
// lsp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsp_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [lsp_pkg::WSUM_W-1:0] numer,
   input  logic [lsp_pkg::WSUM_W-1:0] denom,
   output logic                       done,
   output logic [lsp_pkg::WSUM_W-1:0] quot
);
   localparam int W = lsp_pkg::WSUM_W;

   logic [W-1:0]   quot_ff, quot_in;
   logic [W-1:0]   rem_ff, rem_in;
   logic [W-1:0]   den_ff, den_in;
   logic [4:0]     cnt_ff, cnt_in;
   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [W:0]     trial;
   logic [W:0]     diff;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quot_ff[W-1]};
      diff    = trial - {1'b0, den_ff};
      if (start) begin
         quot_in = numer;
         rem_in  = '0;
         den_in  = denom;
         cnt_in  = 5'(W - 1);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quot_in = {quot_ff[W-2:0], 1'b1};
         end else begin
            rem_in = trial[W-1:0];
            quot_in = {quot_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      cnt_ff  <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

// ===== rtl/lsp_lane.sv =====
// ----------------------------------------------------------------------------
// lsp_lane
// One channel: calibration bounds and scaling of a reading to 0..FULL_SCALE.
// ----------------------------------------------------------------------------
module lsp_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cal_load,
   input  logic                  cal_widen,
   input  lsp_pkg::lane_ctl_type ctl,
   input  lsp_pkg::raw_type      raw,
   output logic                  done,
   output lsp_pkg::cal_type      cal
);
   lsp_pkg::raw_type min_ff, min_in, max_ff, max_in;
   logic [lsp_pkg::WSUM_W-1:0] numer, denom, quot;
   logic zero_ff, zero_in;
   logic [lsp_pkg::NUM_W-1:0] prod;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (cal_load) begin
         min_in = raw;
         max_in = raw;
      end else if (cal_widen) begin
         if (raw < min_ff) min_in = raw;
         if (raw > max_ff) max_in = raw;
      end
   end

   assign prod  = lsp_pkg::NUM_W'(raw - min_ff) * lsp_pkg::NUM_W'(lsp_pkg::FULL_SCALE);
   assign numer = lsp_pkg::WSUM_W'(prod);
   assign denom = lsp_pkg::WSUM_W'(max_ff - min_ff);
   assign zero_in = ctl.start ? ((max_ff <= min_ff) || (raw <= min_ff)) : zero_ff;

   lsp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (ctl.start),
      .numer (numer),
      .denom (denom),
      .done  (done),
      .quot  (quot)
   );

   always_comb begin
      if (zero_ff)
         cal = '0;
      else if (quot > lsp_pkg::WSUM_W'(lsp_pkg::FULL_SCALE))
         cal = lsp_pkg::CAL_W'(lsp_pkg::FULL_SCALE);
      else
         cal = quot[lsp_pkg::CAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      zero_ff <= zero_in;
      if (reset) begin
         min_ff <= lsp_pkg::RAW_W'(lsp_pkg::TIMEOUT_US);
         max_ff <= '0;
      end else begin
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end
endmodule

// ===== rtl/lsp_merge.sv =====
// ----------------------------------------------------------------------------
// lsp_merge
// Accumulates the lane results one channel a cycle; when the line is seen,
// divides for the weighted mean position, else gives the end nearest the last fix.
// ----------------------------------------------------------------------------
module lsp_merge (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  lsp_pkg::cal_type                 cal [lsp_pkg::CHANNELS],
   input  logic [lsp_pkg::CSR_W-1:0]        count_level,
   input  logic [lsp_pkg::CSR_W-1:0]        line_level,
   output logic                             done,
   output logic [lsp_pkg::POS_W-1:0]        position,
   output logic                             on_line
);
   localparam int CH_W = $clog2(lsp_pkg::CHANNELS);

   logic [CH_W-1:0]            ch_ff, ch_in;
   logic                       acc_ff, acc_in;
   logic                       wait_ff, wait_in;
   logic [lsp_pkg::WSUM_W-1:0] wsum_ff, wsum_in;
   logic [lsp_pkg::TSUM_W-1:0] tsum_ff, tsum_in;
   logic                       seen_ff, seen_in;
   logic [lsp_pkg::POS_W-1:0]  held_ff, held_in;
   logic [lsp_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic                       online_ff, online_in;
   logic                       done_ff, done_in;
   lsp_pkg::cal_type           cur;
   logic [lsp_pkg::WSUM_W-1:0] wt;
   logic                       div_start, div_done;
   logic [lsp_pkg::WSUM_W-1:0] quot;

   assign cur = cal[ch_ff];
   assign wt  = lsp_pkg::WSUM_W'(ch_ff) * lsp_pkg::WSUM_W'(lsp_pkg::FULL_SCALE);

   always_comb begin
      ch_in     = ch_ff;
      acc_in    = acc_ff;
      wait_in   = wait_ff;
      wsum_in   = wsum_ff;
      tsum_in   = tsum_ff;
      seen_in   = seen_ff;
      held_in   = held_ff;
      pos_in    = pos_ff;
      online_in = online_ff;
      done_in   = 1'b0;
      div_start = 1'b0;
      if (start) begin
         ch_in   = '0;
         acc_in  = 1'b1;
         wsum_in = '0;
         tsum_in = '0;
         seen_in = 1'b0;
      end else if (acc_ff) begin
         if (cur > count_level) begin
            // one multiplier per cycle: cal times a small channel weight
            wsum_in = wsum_ff + lsp_pkg::WSUM_W'(cur) * wt;
            tsum_in = tsum_ff + lsp_pkg::TSUM_W'(cur);
            if (cur > line_level) seen_in = 1'b1;
         end
         ch_in = ch_ff + 1'b1;
         if (ch_ff == CH_W'(lsp_pkg::CHANNELS - 1)) begin
            acc_in = 1'b0;
            if (seen_in && tsum_in != '0) begin
               div_start = 1'b1;
               wait_in   = 1'b1;
            end else begin
               online_in = 1'b0;
               pos_in = (held_ff < lsp_pkg::POS_W'(lsp_pkg::LINE_MAX / 2)) ?
                        '0 : lsp_pkg::POS_W'(lsp_pkg::LINE_MAX);
               done_in = 1'b1;
            end
         end
      end else if (wait_ff && div_done) begin
         wait_in   = 1'b0;
         pos_in    = quot[lsp_pkg::POS_W-1:0];
         held_in   = quot[lsp_pkg::POS_W-1:0];
         online_in = 1'b1;
         done_in   = 1'b1;
      end
   end

   lsp_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer (wsum_in),
      .denom (lsp_pkg::WSUM_W'(tsum_in)),
      .done  (div_done),
      .quot  (quot)
   );

   always_ff @(posedge clock) begin
      ch_ff     <= ch_in;
      wsum_ff   <= wsum_in;
      tsum_ff   <= tsum_in;
      seen_ff   <= seen_in;
      pos_ff    <= pos_in;
      online_ff <= online_in;
      if (reset) begin
         acc_ff  <= 1'b0;
         wait_ff <= 1'b0;
         done_ff <= 1'b0;
         held_ff <= '0;
      end else begin
         acc_ff  <= acc_in;
         wait_ff <= wait_in;
         done_ff <= done_in;
         held_ff <= held_in;
      end
   end

   assign done     = done_ff;
   assign position = pos_ff;
   assign on_line  = online_ff;
endmodule

// ===== rtl/line_sensor_position.sv =====
// ----------------------------------------------------------------------------
// line_sensor_position
// Weighted line position from a six-channel reflectance sensor array.
// ----------------------------------------------------------------------------
// Usage: the req_ channel carries a command and six raw discharge times.
// Commands start calibration and calibration sample update each channel's
// bounds in the cycle of acceptance and give no item on rsp_; they can be
// accepted one per cycle while req_ready is high. Measure gives one rsp_
// item with position, on_line and six calibrated values.
// A measure: six lanes scale their readings in parallel through bit-serial
// dividers, the merge stage sums the lanes one channel a cycle and, when
// the line is seen, runs a second divider for the mean. One item is in
// work at a time; req_ready is low from the acceptance of a measure until
// its result is in the output register, and a new measure waits until then.
// A stalled receiver holds the rsp_ item in the output register, and req_ready
// stays low while that item waits.
// Reset sets filters to 50 and 200, bounds to 2500/0 and held position to 0.
// csr_ writes land at once; write only while idle.
// ----------------------------------------------------------------------------
module line_sensor_position (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [lsp_pkg::CMD_W-1:0]   req_cmd,
   input  lsp_pkg::raw_type            req_raw_0,
   input  lsp_pkg::raw_type            req_raw_1,
   input  lsp_pkg::raw_type            req_raw_2,
   input  lsp_pkg::raw_type            req_raw_3,
   input  lsp_pkg::raw_type            req_raw_4,
   input  lsp_pkg::raw_type            req_raw_5,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [lsp_pkg::POS_W-1:0]   rsp_position,
   output logic                        rsp_on_line,
   output lsp_pkg::cal_type            rsp_cal_0,
   output lsp_pkg::cal_type            rsp_cal_1,
   output lsp_pkg::cal_type            rsp_cal_2,
   output lsp_pkg::cal_type            rsp_cal_3,
   output lsp_pkg::cal_type            rsp_cal_4,
   output lsp_pkg::cal_type            rsp_cal_5,
   input  logic                        csr_write,
   input  logic [lsp_pkg::IDX_W-1:0]   csr_index,
   input  logic [lsp_pkg::CSR_W-1:0]   csr_data
);
   localparam int N = lsp_pkg::CHANNELS;

   logic [lsp_pkg::CSR_W-1:0] base_ff, online_flt_ff;
   logic                      busy_ff, busy_in;
   logic                      lanes_wait_ff, lanes_wait_in;
   logic                      accept, measure;
   lsp_pkg::lane_ctl_type     ctl;
   lsp_pkg::raw_type          raw [N];
   lsp_pkg::cal_type          cal [N];
   logic [N-1:0]              lane_done;
   logic                      m_done, m_on_line;
   logic [lsp_pkg::POS_W-1:0] m_pos;
   lsp_pkg::cal_type          out_cal_ff [N];
   logic [lsp_pkg::POS_W-1:0] out_pos_ff;
   logic                      out_on_ff;
   logic                      out_valid_ff;

   assign raw[0] = req_raw_0;
   assign raw[1] = req_raw_1;
   assign raw[2] = req_raw_2;
   assign raw[3] = req_raw_3;
   assign raw[4] = req_raw_4;
   assign raw[5] = req_raw_5;

   // Busy covers a measure from accept until its result moves to the output
   // register; that register must be free when the result arrives.
   assign req_ready = !busy_ff && !(out_valid_ff && !rsp_ready);
   assign accept    = req_valid && req_ready;
   assign measure   = accept && (req_cmd == lsp_pkg::CMD_MEASURE);
   assign ctl.start = measure;

   for (genvar g = 0; g < N; g++) begin : g_lane
      lsp_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .cal_load  (accept && req_cmd == lsp_pkg::CMD_START),
         .cal_widen (accept && req_cmd == lsp_pkg::CMD_SAMPLE),
         .ctl       (ctl),
         .raw       (raw[g]),
         .done      (lane_done[g]),
         .cal       (cal[g])
      );
   end

   lsp_merge u_merge (
      .clock       (clock),
      .reset       (reset),
      .start       (lanes_wait_ff && (&lane_done)),
      .cal         (cal),
      .count_level (base_ff),
      .line_level  (online_flt_ff),
      .done        (m_done),
      .position    (m_pos),
      .on_line     (m_on_line)
   );

   always_comb begin
      busy_in       = busy_ff;
      lanes_wait_in = lanes_wait_ff;
      if (measure) begin
         busy_in       = 1'b1;
         lanes_wait_in = 1'b1;
      end else if (lanes_wait_ff && (&lane_done)) begin
         lanes_wait_in = 1'b0;
      end
      // hold busy until the merge result moves to the output register
      if (m_done) busy_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (m_done) begin
         out_pos_ff <= m_pos;
         out_on_ff  <= m_on_line;
         out_cal_ff <= cal;
      end
      if (reset) begin
         base_ff       <= lsp_pkg::CSR_W'(50);
         online_flt_ff <= lsp_pkg::CSR_W'(200);
         busy_ff       <= 1'b0;
         lanes_wait_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               lsp_pkg::REG_COUNT_LEVEL: base_ff       <= csr_data;
               lsp_pkg::REG_LINE_LEVEL:  online_flt_ff <= csr_data;
               default: ;
            endcase
         end
         busy_ff       <= busy_in;
         lanes_wait_ff <= lanes_wait_in;
         if (m_done)
            out_valid_ff <= 1'b1;
         else if (rsp_ready)
            out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_position = out_pos_ff;
   assign rsp_on_line  = out_on_ff;
   assign rsp_cal_0    = out_cal_ff[0];
   assign rsp_cal_1    = out_cal_ff[1];
   assign rsp_cal_2    = out_cal_ff[2];
   assign rsp_cal_3    = out_cal_ff[3];
   assign rsp_cal_4    = out_cal_ff[4];
   assign rsp_cal_5    = out_cal_ff[5];
endmodule

// ===== dv/line_sensor_position_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_position_test
// Self-checking bench for the line sensor position block. Frames are queued
// by a stimulus process and driven by a clocked driver with random gaps. Each
// accepted frame is run through a local calibration and position predictor.
// A clocked monitor with random back-pressure checks every result against
// the oldest prediction. The filters are swept over several settings.
// ----------------------------------------------------------------------------
module line_sensor_position_test;

   localparam logic [lsp_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 6000;
   localparam int SETTLE_CYCLES  = 100;

   typedef struct {
      logic [lsp_pkg::CMD_W-1:0] cmd;
      lsp_pkg::raw_type          raw [lsp_pkg::CHANNELS];
   } frame_type;

   typedef struct {
      logic [lsp_pkg::POS_W-1:0] position;
      logic                      on_line;
      lsp_pkg::cal_type          cal [lsp_pkg::CHANNELS];
   } fix_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [lsp_pkg::CMD_W-1:0] req_cmd = '0;
   lsp_pkg::raw_type req_raw [lsp_pkg::CHANNELS] = '{default: '0};
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [lsp_pkg::POS_W-1:0] rsp_position;
   logic rsp_on_line;
   lsp_pkg::cal_type rsp_cal [lsp_pkg::CHANNELS];
   logic csr_write = 1'b0;
   logic [lsp_pkg::IDX_W-1:0] csr_index = '0;
   logic [lsp_pkg::CSR_W-1:0] csr_data = '0;

   // predictor state
   int unsigned base_thr, line_thr;
   int unsigned bound_lo [lsp_pkg::CHANNELS];
   int unsigned bound_hi [lsp_pkg::CHANNELS];
   int unsigned last_pos;

   frame_type pending_frames [$];
   fix_type   expected_fixes [$];
   frame_type cur_frame;
   int frames_taken = 0;
   int fixes_seen = 0;
   int errors = 0;
   int settings = 1;
   int idle_cycles = 0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   always #10 clock = ~clock;

   line_sensor_position u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(req_cmd),
      .req_raw_0(req_raw[0]), .req_raw_1(req_raw[1]), .req_raw_2(req_raw[2]),
      .req_raw_3(req_raw[3]), .req_raw_4(req_raw[4]), .req_raw_5(req_raw[5]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_position(rsp_position), .rsp_on_line(rsp_on_line),
      .rsp_cal_0(rsp_cal[0]), .rsp_cal_1(rsp_cal[1]), .rsp_cal_2(rsp_cal[2]),
      .rsp_cal_3(rsp_cal[3]), .rsp_cal_4(rsp_cal[4]), .rsp_cal_5(rsp_cal[5]),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   function automatic int unsigned scale_reading(int unsigned raw, int unsigned lo,
                                                 int unsigned hi);
      int unsigned v;
      if (hi <= lo || raw <= lo) return 0;
      v = ((raw - lo) * lsp_pkg::FULL_SCALE) / (hi - lo);
      return (v > lsp_pkg::FULL_SCALE) ? lsp_pkg::FULL_SCALE : v;
   endfunction

   // Update calibration or work out the position fix for one accepted frame.
   task automatic track_frame(frame_type f);
      fix_type fx;
      int unsigned weighted, total, c;
      bit seen;
      weighted = 0;
      total = 0;
      seen = 1'b0;
      unique case (f.cmd)
         lsp_pkg::CMD_START: begin
            foreach (f.raw[i]) begin
               bound_lo[i] = f.raw[i];
               bound_hi[i] = f.raw[i];
            end
         end
         lsp_pkg::CMD_SAMPLE: begin
            foreach (f.raw[i]) begin
               if (f.raw[i] < bound_lo[i]) bound_lo[i] = f.raw[i];
               if (f.raw[i] > bound_hi[i]) bound_hi[i] = f.raw[i];
            end
         end
         lsp_pkg::CMD_MEASURE: begin
            foreach (f.raw[i]) begin
               c = scale_reading(f.raw[i], bound_lo[i], bound_hi[i]);
               fx.cal[i] = c[lsp_pkg::CAL_W-1:0];
               if (c > base_thr) begin
                  weighted += c * i * lsp_pkg::FULL_SCALE;
                  total += c;
                  if (c > line_thr) seen = 1'b1;
               end
            end
            if (seen && total != 0) begin
               last_pos = (weighted / total) & 13'h1fff;
               fx.position = last_pos[lsp_pkg::POS_W-1:0];
            end else begin
               seen = 1'b0;
               fx.position = (last_pos < lsp_pkg::LINE_MAX / 2) ?
                             '0 : lsp_pkg::POS_W'(lsp_pkg::LINE_MAX);
            end
            fx.on_line = seen;
            expected_fixes.push_back(fx);
         end
         default: ;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_frame(cur_frame);
            frames_taken++;
         end
         if (!req_valid || req_ready) begin
            if (pending_frames.size() > 0 &&
                ((frames_taken > 400 && frames_taken < 560) ||
                 $urandom_range(0, 99) >= 29)) begin
               cur_frame = pending_frames.pop_front();
               req_cmd <= cur_frame.cmd;
               foreach (req_raw[i]) req_raw[i] <= cur_frame.raw[i];
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
      if (exp_v != act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         errors++;
      end
   endtask

   // monitor
   always @(posedge clock) begin
      fix_type fx;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            fixes_seen++;
            if (expected_fixes.size() == 0) begin
               $error("result with no frame pending");
               errors++;
            end else begin
               fx = expected_fixes.pop_front();
               check_field("position", fx.position, rsp_position);
               check_field("on_line", fx.on_line, rsp_on_line);
               foreach (fx.cal[i])
                  check_field($sformatf("cal_%0d", i), fx.cal[i], rsp_cal[i]);
            end
         end
         // one long hold-off so the block backs up into the sender
         if (!hold_done && fixes_seen == 30) begin
            hold_done <= 1'b1;
            hold_left <= 400;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
         end
         if (hold_left > 1 || (!hold_done && fixes_seen == 30))
            rsp_ready <= 1'b0;
         else
            rsp_ready <= (fixes_seen > 200 && fixes_seen < 300) ||
                         $urandom_range(0, 99) >= 29;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("line_sensor_position_test failed");
         $finish;
      end
   end

   task automatic add_frame(logic [lsp_pkg::CMD_W-1:0] cmd, int unsigned r0,
                            int unsigned r1, int unsigned r2, int unsigned r3,
                            int unsigned r4, int unsigned r5);
      frame_type f;
      f.cmd = cmd;
      f.raw = '{lsp_pkg::RAW_W'(r0), lsp_pkg::RAW_W'(r1), lsp_pkg::RAW_W'(r2),
                lsp_pkg::RAW_W'(r3), lsp_pkg::RAW_W'(r4), lsp_pkg::RAW_W'(r5)};
      pending_frames.push_back(f);
   endtask

   task automatic drain();
      while (pending_frames.size() > 0 || req_valid || expected_fixes.size() > 0)
         @(posedge clock);
      // calibration frames give no result; let the last one settle
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_filters(int unsigned base_v, int unsigned line_v);
      drain();
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= lsp_pkg::REG_COUNT_LEVEL;
      csr_data <= lsp_pkg::CSR_W'(base_v);
      base_thr = base_v & 10'h3ff;
      @(posedge clock);
      csr_index <= lsp_pkg::REG_LINE_LEVEL;
      csr_data <= lsp_pkg::CSR_W'(line_v);
      line_thr = line_v & 10'h3ff;
      @(posedge clock);
      csr_write <= 1'b0;
      settings++;
   endtask

   // Calibrate, then mostly frames with a bright spot around one channel.
   task automatic random_phase(int n);
      frame_type f;
      int unsigned lo [lsp_pkg::CHANNELS];
      int unsigned hi [lsp_pkg::CHANNELS];
      int unsigned w, r;
      int peak, d;
      foreach (lo[i]) begin
         lo[i] = $urandom_range(0, 2000);
         hi[i] = ($urandom_range(0, 7) == 0) ? lo[i] : lo[i] + $urandom_range(1, 2095);
      end
      add_frame(lsp_pkg::CMD_START, lo[0], lo[1], lo[2], lo[3], lo[4], lo[5]);
      add_frame(lsp_pkg::CMD_SAMPLE, hi[0], hi[1], hi[2], hi[3], hi[4], hi[5]);
      for (int k = 0; k < n; k++) begin
         r = $urandom_range(0, 99);
         f.cmd = lsp_pkg::CMD_MEASURE;
         peak = $urandom_range(0, lsp_pkg::CHANNELS - 1);
         foreach (f.raw[i]) begin
            d = (i > peak) ? i - peak : peak - i;
            if (r < 12) begin
               f.raw[i] = $urandom_range(0, 4095);
            end else begin
               if (r < 22) w = $urandom_range(0, 250);
               else if (d == 0) w = $urandom_range(600, 1200);
               else if (d == 1) w = $urandom_range(0, 800);
               else w = $urandom_range(0, 150);
               f.raw[i] = lsp_pkg::RAW_W'(
                  (lo[i] + (hi[i] - lo[i]) * w / 1000 > 4095) ? 4095 :
                  lo[i] + (hi[i] - lo[i]) * w / 1000);
            end
         end
         if (r < 6) f.cmd = lsp_pkg::CMD_W'($urandom_range(0, 3));
         if (f.cmd == CMD_UNUSED) k--;
         pending_frames.push_back(f);
      end
   endtask

   initial begin
      base_thr = 50;
      line_thr = 200;
      last_pos = 0;
      foreach (bound_lo[i]) begin
         bound_lo[i] = lsp_pkg::TIMEOUT_US;
         bound_hi[i] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // uncalibrated: zero span on every channel, line lost at the low end
      add_frame(lsp_pkg::CMD_MEASURE, 0, 4095, 2500, 1000, 4095, 7);
      add_frame(CMD_UNUSED, 4095, 4095, 4095, 4095, 4095, 4095);
      add_frame(lsp_pkg::CMD_START, 0, 0, 0, 0, 0, 0);
      add_frame(lsp_pkg::CMD_SAMPLE, 4095, 4095, 4095, 4095, 4095, 4095);
      add_frame(lsp_pkg::CMD_MEASURE, 0, 0, 0, 0, 0, 0);
      add_frame(lsp_pkg::CMD_MEASURE, 4095, 4095, 4095, 4095, 4095, 4095);
      add_frame(lsp_pkg::CMD_MEASURE, 4095, 0, 0, 0, 0, 0);
      add_frame(lsp_pkg::CMD_MEASURE, 0, 0, 0, 0, 0, 4095);
      // lost after a right-hand fix: report the high end
      add_frame(lsp_pkg::CMD_MEASURE, 0, 0, 0, 0, 0, 0);
      add_frame(lsp_pkg::CMD_MEASURE, 0, 0, 2048, 4095, 2048, 0);
      add_frame(lsp_pkg::CMD_MEASURE, 205, 0, 0, 0, 0, 0);
      add_frame(lsp_pkg::CMD_MEASURE, 0, 0, 1000, 0, 0, 819);
      // narrow bounds, readings outside them clamp
      add_frame(lsp_pkg::CMD_START, 1000, 1000, 1000, 1000, 1000, 1000);
      add_frame(lsp_pkg::CMD_SAMPLE, 1010, 1003, 999, 1001, 1500, 900);
      add_frame(lsp_pkg::CMD_SAMPLE, 2000, 0, 1200, 1000, 1000, 1000);
      add_frame(lsp_pkg::CMD_MEASURE, 4095, 4095, 0, 1001, 1250, 950);
      add_frame(lsp_pkg::CMD_MEASURE, 1005, 1002, 1100, 1000, 1499, 4000);
      random_phase(180);

      set_filters(0, 0);
      random_phase(180);
      set_filters(1000, 1000);
      random_phase(120);
      set_filters(1023, 0);
      random_phase(100);
      set_filters($urandom_range(0, 300), $urandom_range(100, 700));
      random_phase(240);
      set_filters(50, 200);
      random_phase(260);
      drain();

      $display("covered %0d frames and %0d position fixes over %0d filter settings",
               frames_taken, fixes_seen, settings);
      if (errors == 0)
         $display("line_sensor_position_test passed");
      else
         $display("line_sensor_position_test failed");
      $finish;
   end

endmodule
